// ----- src/dqe_pkg.sv -----
// Package for the DNS question encoder: command and result types, codes and defaults.
// Used by every module of the block except dqe_fifo; depends on nothing.
package dqe_pkg;

    // default label length limit and queue depths
    localparam int MAX_LABEL_DEF = 63;
    localparam int CMD_DEPTH     = 2;
    localparam int OUT_DEPTH     = 2;

    // character that separates labels
    localparam logic [7:0] DOT_CHAR = 8'h2e;

    // register reset values and register indexes
    localparam logic [15:0] QTYPE_RST  = 16'd1;
    localparam logic [15:0] QCLASS_RST = 16'd1;
    localparam logic        REG_QTYPE  = 1'b0;
    localparam logic        REG_QCLASS = 1'b1;

    // input opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_NODOT = 2'd2;

    // steps of the trailer emitted on end of name
    localparam logic [2:0] END_ZERO     = 3'd0;
    localparam logic [2:0] END_TYPE_HI  = 3'd1;
    localparam logic [2:0] END_TYPE_LO  = 3'd2;
    localparam logic [2:0] END_CLASS_HI = 3'd3;
    localparam logic [2:0] END_CLASS_LO = 3'd4;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_DOT,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic [1:0] status;
    } result_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LEN,
        B_BODY,
        B_END
    } back_state_t;

endpackage

// ----- src/dqe_fifo.sv -----
// Small synchronous queue used between the front and back parts and at the result side.
// Depends on nothing; width and depth come from the instantiating module.
module dqe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store[rd_ptr_reg];

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // write storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue occupancy beyond depth");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue occupancy did not drop on pop");
    a_push_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue occupancy did not grow on push");
`endif

endmodule

// ----- src/dqe_front.sv -----
// Front part of the DNS question encoder: takes input transactions and classifies them
// into character, dot and end commands. Depends on dqe_pkg.
module dqe_front (
    input  logic          push,
    input  logic          opcode,
    input  logic [7:0]    name_char,
    input  logic          cmd_full,
    output logic          cmd_push,
    output dqe_pkg::cmd_t cmd
);

    assign cmd_push = push && !cmd_full;

    // classify the item
    always_comb
    begin
        cmd.ch = name_char;
        if (opcode == dqe_pkg::OP_END)
        begin
            cmd.kind = dqe_pkg::CMD_END;
        end
        else if (name_char == dqe_pkg::DOT_CHAR)
        begin
            cmd.kind = dqe_pkg::CMD_DOT;
        end
        else
        begin
            cmd.kind = dqe_pkg::CMD_CHAR;
        end
    end

endmodule

// ----- src/dqe_back.sv -----
// Back part of the DNS question encoder: label buffer, sequencer that replays labels
// and emits the name trailer one byte per cycle unless out_full. Depends on dqe_pkg.
module dqe_back #(
    parameter int MAX_LABEL = dqe_pkg::MAX_LABEL_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  dqe_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic [15:0]      query_type,
    input  logic [15:0]      query_class,
    input  logic             out_full,
    output logic             out_push,
    output dqe_pkg::result_t out_item
);

    // clamp the label limit to the range a length byte can describe
    localparam int LIM   = (MAX_LABEL > 63) ? 63 : ((MAX_LABEL < 1) ? 1 : MAX_LABEL);
    localparam int CW    = $clog2(LIM + 1);
    localparam int DEPTH = 2 ** CW;
    localparam logic [CW-1:0] LIMIT = CW'(LIM);

    dqe_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [2:0]    step_reg, step_next;
    logic [1:0]    st_reg, st_next;
    logic [7:0]    label_mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] rd_addr;
    logic          wr_en;
    logic          body_last;
    logic          end_last;
    logic          have_label;

    assign have_label = (count_reg != '0);
    assign body_last  = (idx_reg == count_reg - 1'b1);
    assign end_last   = (step_reg == dqe_pkg::END_CLASS_LO);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dqe_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == dqe_pkg::CMD_DOT && have_label)
                    begin
                        state_next = dqe_pkg::B_LEN;
                    end
                    else if (cmd.kind == dqe_pkg::CMD_END)
                    begin
                        state_next = dqe_pkg::B_END;
                    end
                end
            end
            dqe_pkg::B_LEN:
            begin
                if (!out_full)
                begin
                    state_next = dqe_pkg::B_BODY;
                end
            end
            dqe_pkg::B_BODY:
            begin
                if (!out_full && body_last)
                begin
                    state_next = dqe_pkg::B_IDLE;
                end
            end
            dqe_pkg::B_END:
            begin
                if (!out_full && end_last)
                begin
                    state_next = dqe_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dqe_pkg::B_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        cmd_pop    = (state_reg == dqe_pkg::B_IDLE) && cmd_valid;
        out_push   = (state_reg != dqe_pkg::B_IDLE) && !out_full;
        wr_en      = 1'b0;
        rd_addr    = '0;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        st_next    = st_reg;
        out_item.out_byte    = 8'h00;
        out_item.last_of_run = 1'b0;
        out_item.status      = st_reg;
        unique case (state_reg)
            dqe_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        dqe_pkg::CMD_CHAR:
                        begin
                            // buffer the character or drop it past the limit
                            if (count_reg < LIMIT)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        dqe_pkg::CMD_DOT:
                        begin
                            st_next = ovf_reg ? dqe_pkg::ST_TRUNC : dqe_pkg::ST_OK;
                        end
                        dqe_pkg::CMD_END:
                        begin
                            step_next = dqe_pkg::END_ZERO;
                            if (have_label)
                            begin
                                st_next = dqe_pkg::ST_NODOT;
                            end
                            else
                            begin
                                st_next = ovf_reg ? dqe_pkg::ST_TRUNC : dqe_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            st_next = st_reg;
                        end
                    endcase
                end
            end
            dqe_pkg::B_LEN:
            begin
                // emit the length byte and fetch the first label byte
                out_item.out_byte = 8'(count_reg);
                rd_addr           = '0;
                if (!out_full)
                begin
                    idx_next = '0;
                end
            end
            dqe_pkg::B_BODY:
            begin
                out_item.out_byte    = rd_data_reg;
                out_item.last_of_run = body_last;
                rd_addr              = idx_reg;
                if (!out_full)
                begin
                    if (body_last)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            dqe_pkg::B_END:
            begin
                out_item.last_of_run = end_last;
                unique case (step_reg)
                    dqe_pkg::END_ZERO:     out_item.out_byte = 8'h00;
                    dqe_pkg::END_TYPE_HI:  out_item.out_byte = query_type[15:8];
                    dqe_pkg::END_TYPE_LO:  out_item.out_byte = query_type[7:0];
                    dqe_pkg::END_CLASS_HI: out_item.out_byte = query_class[15:8];
                    dqe_pkg::END_CLASS_LO: out_item.out_byte = query_class[7:0];
                    default:               out_item.out_byte = 8'h00;
                endcase
                if (!out_full)
                begin
                    if (end_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                out_item.out_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqe_pkg::B_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            step_reg  <= dqe_pkg::END_ZERO;
            st_reg    <= dqe_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            st_reg    <= st_next;
        end
    end

    // label buffer: write on character, registered read for replay
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_mem[count_reg] <= cmd.ch;
        end
        rd_data_reg <= label_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_push && out_full))
        else $error("result pushed into a full queue");
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT)
        else $error("label count beyond limit");
    a_body_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqe_pkg::B_BODY) |-> (idx_reg < count_reg))
        else $error("replay index beyond buffered label");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_item.last_of_run) |=> (state_reg == dqe_pkg::B_IDLE))
        else $error("sequencer busy after last result of a run");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_item.last_of_run && state_reg == dqe_pkg::B_END)
        |=> (count_reg == '0 && !ovf_reg))
        else $error("name state not cleared after end");
`endif

endmodule

// ----- src/dns_question_encoder_unit.sv -----
// DNS question encoder top level: configuration registers, front part, command queue,
// back part and result queue. Depends on dqe_pkg, dqe_front, dqe_fifo and dqe_back.
//
// Usage: push one transaction per name character (opcode 0) and one end transaction
// (opcode 1) per name; the name must end with a dot. A transaction is taken at a
// rising edge with push high and full low. Results are read like a queue: while
// empty is low, out_byte, last_of_run and status show the oldest result; pop takes it.
// A dot replays the buffered label as a length byte and the label bytes; the end
// transaction gives the zero byte, query type and query class, high byte first.
// A character is taken by the back part in its idle state; a dot with N buffered bytes
// is taken as a command and then gives the length byte and N label bytes, and an end
// gives five bytes (zero byte, query type, query class) after it is taken. The back
// part emits a single output byte per cycle while the result queue has room, and
// takes no new command until its run is done. When the receiver stops popping, the
// result queue fills, the back part holds, then the command queue fills and full rises.
// Reset empties both queues, clears the pending label and the truncation flag, and sets
// query type and class to 1. Configuration through the APB port only while no name is
// in progress; the user must keep to this, the block itself does not enforce it.
module dns_question_encoder_unit #(
    parameter int MAX_LABEL = dqe_pkg::MAX_LABEL_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [7:0]  name_char,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic [1:0]  status,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CMD_W = $bits(dqe_pkg::cmd_t);
    localparam int RES_W = $bits(dqe_pkg::result_t);

    logic [15:0]      qtype_reg;
    logic [15:0]      qclass_reg;
    logic             cfg_wr;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    dqe_pkg::cmd_t    cmd_in;
    dqe_pkg::cmd_t    cmd_out;
    logic             res_push;
    logic             res_full;
    dqe_pkg::result_t res_in;
    dqe_pkg::result_t res_out;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qtype_reg  <= dqe_pkg::QTYPE_RST;
            qclass_reg <= dqe_pkg::QCLASS_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == dqe_pkg::REG_QCLASS)
            begin
                qclass_reg <= pwdata[15:0];
            end
            else
            begin
                qtype_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == dqe_pkg::REG_QTYPE) ? {16'h0000, qtype_reg}
                                                     : {16'h0000, qclass_reg};

    // front: classify incoming transactions
    dqe_front u_front (
        .push      (push),
        .opcode    (opcode),
        .name_char (name_char),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    assign full = cmd_full;

    dqe_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (dqe_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // back: buffer labels and emit bytes
    dqe_back #(
        .MAX_LABEL (MAX_LABEL)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (!cmd_empty),
        .cmd         (cmd_out),
        .cmd_pop     (cmd_pop),
        .query_type  (qtype_reg),
        .query_class (qclass_reg),
        .out_full    (res_full),
        .out_push    (res_push),
        .out_item    (res_in)
    );

    dqe_fifo #(
        .WIDTH (RES_W),
        .DEPTH (dqe_pkg::OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign out_byte    = res_out.out_byte;
    assign last_of_run = res_out.last_of_run;
    assign status      = res_out.status;

endmodule
